// File: src/mt_pkg.sv
`default_nettype none

package mt_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t HIGH_BIT     = 32'h8000_0000;
  localparam word_t LOW_BITS     = 32'h7fff_ffff;
  localparam word_t KNUTH_MULT   = 32'd1812433253;
  localparam word_t DEFAULT_SEED = 32'd5489;
  localparam word_t ALL_ONES     = 32'hffff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;

  // Status of the seeding sequencer
  typedef struct packed {
    logic busy;
    logic last;
  } seed_status_t;

  // Fixed taps of the state chain
  typedef struct packed {
    word_t first;
    word_t second;
    word_t far;
    word_t last;
  } chain_taps_t;

  // Twist recurrence for one word
  function automatic word_t mt_mix(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t v;
    y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // Output tempering
  function automatic word_t mt_temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// File: src/mt_cell.sv
`default_nettype none

module mt_cell
  import mt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift_en,
  input  wire word_t d_in,
  output word_t      q
);

  word_t word_r;

  // Take the neighbor's word on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;

endmodule

`default_nettype wire

// File: src/mt_chain.sv
`default_nettype none

module mt_chain
  import mt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  shift_en,
  input  wire word_t push_word,
  output chain_taps_t taps
);

  word_t cell_q [STATE_WORDS];

  // Row of cells; each shift moves every word one place toward the head
  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    if (i == STATE_WORDS - 1) begin : g_tail
      mt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (push_word),
        .q        (cell_q[i])
      );
    end else begin : g_body
      mt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[i+1]),
        .q        (cell_q[i])
      );
    end
  end

  // Expose the fixed taps used by twist and seeding
  assign taps.first  = cell_q[0];
  assign taps.second = cell_q[1];
  assign taps.far    = cell_q[SHIFT_OFFSET];
  assign taps.last   = cell_q[STATE_WORDS-1];

endmodule

`default_nettype wire

// File: src/mt_seeder.sv
`default_nettype none

module mt_seeder
  import mt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire word_t seed,
  input  wire word_t prev_word,
  output word_t      push_word,
  output seed_status_t status
);

  logic  busy_r, busy_nxt;
  idx_t  cnt_r, cnt_nxt;
  word_t seed_eff;
  word_t folded;
  word_t prod;

  // Swap an all-ones seed for the default
  assign seed_eff = (seed == ALL_ONES) ? DEFAULT_SEED : seed;

  // Knuth recurrence on the last pushed word
  assign folded    = prev_word ^ (prev_word >> 30);
  assign prod      = KNUTH_MULT * folded;
  assign push_word = (cnt_r == '0) ? seed_eff : prod + WORD_W'(cnt_r);

  assign status.busy = busy_r;
  assign status.last = busy_r && (cnt_r == IDX_W'(STATE_WORDS - 1));

  // Advance the word counter while seeding
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (status.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/mt19937_generator.sv
`default_nettype none
// A result word is registered and becomes valid in the cycle after its request word is accepted.
// Throughput: one word per cycle while out_ready is held, set by one shift of the 624-cell state chain.
// After reset or a seed write, the first request waits while the seeding sequencer starts
// and then pushes the seed and its Knuth words, 624 in all, one word per cycle, into the chain.
// Reset: seed 5489, generator unseeded, no result pending; chain contents undefined.

module mt19937_generator
  import mt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  in_request,
  output logic       out_valid,
  input  wire logic  out_ready,
  output word_t      out_random_word,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire word_t cfg_seed
);

  typedef enum logic [2:0] {
    ST_UNSEEDED = 3'b001,
    ST_SEEDING  = 3'b010,
    ST_RUN      = 3'b100
  } state_t;

  state_t       state_r, state_nxt;
  word_t        seed_r;
  logic         out_valid_r, out_valid_nxt;
  word_t        out_word_r;
  logic         seed_start;
  logic         gen_fire;
  logic         shift_en;
  word_t        seed_word;
  word_t        twist_word;
  word_t        push_word;
  seed_status_t seed_stat;
  chain_taps_t  taps;

  // Handshakes
  assign cfg_ready  = (state_r != ST_SEEDING);
  assign in_ready   = ((state_r == ST_RUN) && (!out_valid_r || out_ready)) ||
                      ((state_r == ST_UNSEEDED) && !in_request);
  assign seed_start = (state_r == ST_UNSEEDED) && in_valid && in_request && !cfg_valid;
  assign gen_fire   = (state_r == ST_RUN) && in_valid && in_ready && in_request;

  // Chain feed: seed words while seeding, twisted words while running
  assign twist_word = mt_mix(taps.first, taps.second, taps.far);
  assign push_word  = seed_stat.busy ? seed_word : twist_word;
  assign shift_en   = seed_stat.busy || gen_fire;

  mt_seeder u_seeder (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (seed_start),
    .seed      (seed_r),
    .prev_word (taps.last),
    .push_word (seed_word),
    .status    (seed_stat)
  );

  mt_chain u_chain (
    .clk       (clk),
    .shift_en  (shift_en),
    .push_word (push_word),
    .taps      (taps)
  );

  // Sequence seeding and generation
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_UNSEEDED: begin
        if (seed_start) begin
          state_nxt = ST_SEEDING;
        end
      end
      ST_SEEDING: begin
        if (seed_stat.last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_UNSEEDED;
      end
    endcase
    if (cfg_valid && cfg_ready) begin
      state_nxt = ST_UNSEEDED;
    end
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (gen_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_UNSEEDED;
      seed_r      <= DEFAULT_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      out_word_r <= mt_temper(twist_word);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

`ifndef SYNTHESIS
  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    gen_fire |=> out_valid)
    else $error("accepted request did not produce a word");

  a_seeding_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEEDING) |-> (!in_ready && !cfg_ready))
    else $error("input or seed write taken during seeding");

  a_seed_done_runs: assert property (@(posedge clk) disable iff (!rst_n)
    seed_stat.last |=> (state_r == ST_RUN))
    else $error("seeding finished without entering run");

  a_seeder_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    seed_stat.busy |-> (state_r == ST_SEEDING))
    else $error("seeder busy outside seeding");
`endif

endmodule

`default_nettype wire
